// File: design/srce_pkg.sv
// Package for the stack/register CPU execute block: opcodes, error codes, sizes.
package srce_pkg;
  localparam int unsigned NumRegsDef    = 8;
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned CallDepthDef  = 64;
  localparam int unsigned AddrW         = 2;
  localparam logic [AddrW-1:0] RegProgLen = 2'd0;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
    OP_MUL = 5'd5, OP_DIV = 5'd6, OP_SQRT = 5'd7, OP_JMP = 5'd8, OP_JGE = 5'd9,
    OP_JG = 5'd10, OP_JLE = 5'd11, OP_JL = 5'd12, OP_JE = 5'd13, OP_JNE = 5'd14,
    OP_IN = 5'd15, OP_INREG = 5'd16, OP_OUT = 5'd17, OP_ADDREG = 5'd18,
    OP_SUBREG = 5'd19, OP_MULREG = 5'd20, OP_DIVREG = 5'd21, OP_SQRTREG = 5'd22,
    OP_CALL = 5'd23, OP_RET = 5'd24, OP_HLT = 5'd25
  } op_e;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_DIV0 = 4'd1, ERR_NEGROOT = 4'd2, ERR_SUNDER = 4'd3,
    ERR_SOVER = 4'd4, ERR_CUNDER = 4'd5, ERR_COVER = 4'd6, ERR_BADREG = 4'd7,
    ERR_BADOP = 4'd8
  } err_e;

  // Request to and answer from the iterative divide/root unit
  typedef struct packed {
    logic        start;
    logic        is_root;
    logic [31:0] a;
    logic [31:0] b;
  } it_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } it_rsp_t;
endpackage

// File: design/srce_if.sv
// Valid/ready channel interfaces for instruction items and result items.
interface srce_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic signed [31:0] arg_first;
  logic signed [31:0] arg_second;
  logic signed [31:0] arg_third;
  modport source (output valid, cmd, arg_first, arg_second, arg_third, input ready);
  modport sink (input valid, cmd, arg_first, arg_second, arg_third, output ready);
endinterface

interface srce_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_index;
  logic        out_valid;
  logic signed [31:0] out_value;
  logic        halted;
  logic [3:0]  error_code;
  modport source (output valid, next_index, out_valid, out_value, halted, error_code,
                  input ready);
  modport sink (input valid, next_index, out_valid, out_value, halted, error_code,
                output ready);
endinterface

// File: design/srce_iter.sv
// Shared iterative unit: signed 32-bit division or integer square root, one bit a cycle.
module srce_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srce_pkg::it_req_t   req_i,
  output srce_pkg::it_rsp_t   rsp_o
);
  import srce_pkg::*;

  logic        busy_q, busy_d;
  logic        root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;   // dividend shifted out / radicand
  logic [31:0] den_q, den_d;   // magnitude of divisor
  logic [32:0] rem_q, rem_d;   // partial remainder
  logic [31:0] quo_q, quo_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [33:0] trial;
  logic [33:0] rrem;
  logic [33:0] rtry;

  always_comb begin
    busy_d = busy_q; root_d = root_q; cnt_d = cnt_q; num_d = num_q; den_d = den_q;
    rem_d = rem_q; quo_d = quo_q; neg_d = neg_q; done_d = 1'b0;
    trial = '0; rrem = '0; rtry = '0;
    if (req_i.start) begin
      busy_d = 1'b1; root_d = req_i.is_root; cnt_d = 6'd0; rem_d = '0; quo_d = '0;
      if (req_i.is_root) begin
        num_d = req_i.a; neg_d = 1'b0; den_d = '0;
      end else begin
        num_d = req_i.a[31] ? 32'(-req_i.a) : req_i.a;
        den_d = req_i.b[31] ? 32'(-req_i.b) : req_i.b;
        neg_d = req_i.a[31] ^ req_i.b[31];
      end
    end else if (busy_q) begin
      if (!root_q) begin
        // restoring division step
        trial = {rem_q, num_q[31]} - {2'b00, den_q};
        num_d = {num_q[30:0], 1'b0};
        if (!trial[33]) begin
          rem_d = trial[32:0]; quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], num_q[31]}; quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_d = 1'b0; done_d = 1'b1;
        end
      end else begin
        // digit-by-digit root, two radicand bits per cycle
        rrem = {rem_q[31:0], num_q[31:30]};
        rtry = rrem - {quo_q, 2'b01};
        num_d = {num_q[29:0], 2'b00};
        if (!rtry[33]) begin
          rem_d = rtry[32:0]; quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rrem[32:0]; quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd15) begin
          busy_d = 1'b0; done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d; num_q <= num_d; den_q <= den_d; rem_q <= rem_d;
    quo_q <= quo_d; neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? 32'(-quo_q) : quo_q;
endmodule

// File: design/stack_register_cpu_execute.sv
// Top level of the stack/register CPU execute block.
//  channel | dir | handshake     | payload
//  in_if   | in  | valid/ready   | cmd, arg_first, arg_second, arg_third
//  out_if  | out | valid/ready   | next_index, out_valid, out_value, halted, error_code
//  apb     | in  | psel/penable  | program_length at address 0
// Simple ops pass the read and execute states, then offer their result;
// the block takes no new item until that result has left.
// div, divreg, sqrt and sqrtreg also pass a wait state for the shared divide/root
// unit, which starts on the first wait cycle and resolves one bit per cycle.
// Reset clears registers, depths, index and stop flag at once; no clearing pass.
// A stalled result holds in the output register; no new item is taken until it leaves.
module stack_register_cpu_execute #(
  parameter int unsigned NUM_REGS    = srce_pkg::NumRegsDef,
  parameter int unsigned STACK_DEPTH = srce_pkg::StackDepthDef,
  parameter int unsigned CALL_DEPTH  = srce_pkg::CallDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  srce_in_if.sink                    in_if,
  srce_out_if.source                 out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [srce_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import srce_pkg::*;

  localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(CALL_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_WAIT, S_OUT} state_e;

  state_e      state_q;
  logic [15:0] plen_q;
  logic [31:0] rf_q [NUM_REGS];
  logic [31:0] dstk [STACK_DEPTH];
  logic [15:0] cstk [CALL_DEPTH];
  logic [SW:0] dd_q;
  logic [CW:0] cd_q;
  logic [15:0] idx_q;
  logic        stop_q;
  logic [3:0]  err_q;
  logic [4:0]  cmd_q;
  logic [31:0] a0_q, a1_q, a2_q;
  logic [31:0] x_q, y_q;        // top and second of data stack
  logic [15:0] ret_q;           // top of call stack
  logic        oval_q, ohalt_q;
  logic [31:0] oval_v_q;
  logic [15:0] onext_q;
  logic [3:0]  oerr_q;
  logic        start_q;
  it_req_t     ureq;
  it_rsp_t     ursp;

  srce_iter u_iter (.clk_i, .rst_ni, .req_i(ureq), .rsp_o(ursp));

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == RegProgLen) ? {16'd0, plen_q} : 32'd0;

  function automatic logic rok(logic [31:0] v);
    return v < 32'(NUM_REGS);
  endfunction

  function automatic logic [15:0] clampt(logic [31:0] v);
    if (v[31]) return 16'd0;
    if (v > 32'd65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // decode of the held item
  logic [31:0] r0, r1;
  logic        ok0, ok1, ok2;
  logic        take;
  logic signed [31:0] rsv;
  logic [31:0] mul_a, mul_b, mul_r;

  assign ok0 = rok(a0_q);
  assign ok1 = rok(a1_q);
  assign ok2 = rok(a2_q);
  assign r0  = rf_q[a0_q[RW-1:0]];
  assign r1  = rf_q[a1_q[RW-1:0]];
  assign rsv = $signed(r1);
  assign mul_a = (cmd_q == OP_MULREG) ? r0 : x_q;
  assign mul_b = (cmd_q == OP_MULREG) ? r1 : y_q;
  assign mul_r = mul_a * mul_b;

  always_comb begin
    case (cmd_q)
      OP_JGE:  take = rsv >= $signed(a2_q);
      OP_JG:   take = rsv >  $signed(a2_q);
      OP_JLE:  take = rsv <= $signed(a2_q);
      OP_JL:   take = rsv <  $signed(a2_q);
      OP_JE:   take = rsv == $signed(a2_q);
      default: take = rsv != $signed(a2_q);
    endcase
  end

  assign in_if.ready    = (state_q == S_IDLE);
  assign out_if.valid   = (state_q == S_OUT);
  assign out_if.next_index = onext_q;
  assign out_if.out_valid  = oval_q;
  assign out_if.out_value  = oval_v_q;
  assign out_if.halted     = ohalt_q;
  assign out_if.error_code = oerr_q;

  // stack memories: registered reads of the top entries
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid) begin
      x_q   <= dstk[SW'(dd_q - 1'b1)];
      y_q   <= dstk[SW'(dd_q - 2'd2)];
      ret_q <= cstk[CW'(cd_q - 1'b1)];
    end
    if (state_q == S_EXEC && !stop_q && idx_q < plen_q) begin
      if (cmd_q == OP_PUSH && dd_q < STACK_DEPTH[SW:0])
        dstk[dd_q[SW-1:0]] <= a0_q;
      if ((cmd_q == OP_ADD || cmd_q == OP_SUB || cmd_q == OP_MUL) && dd_q >= 2)
        dstk[SW'(dd_q - 2'd2)] <= (cmd_q == OP_ADD) ? x_q + y_q :
                                  (cmd_q == OP_SUB) ? x_q - y_q : mul_r;
      if (cmd_q == OP_CALL && cd_q < CALL_DEPTH[CW:0])
        cstk[cd_q[CW-1:0]] <= 16'(idx_q + 16'd1);
    end
    if (state_q == S_WAIT && ursp.done) begin
      // div replaces the second entry, which becomes the new top
      if (cmd_q == OP_DIV) dstk[SW'(dd_q - 2'd2)] <= ursp.res;
      if (cmd_q == OP_SQRT) dstk[SW'(dd_q - 1'b1)] <= ursp.res;
    end
  end

  // request to the shared unit; start pulses on the first wait cycle
  always_comb begin
    ureq = '0;
    ureq.start = start_q && (state_q == S_WAIT);
    ureq.is_root = (cmd_q == OP_SQRT || cmd_q == OP_SQRTREG);
    ureq.a = (cmd_q == OP_DIV || cmd_q == OP_SQRT) ? x_q : r0;
    ureq.b = (cmd_q == OP_DIV) ? y_q : r1;
  end

  // sequencer: state, architectural state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; plen_q <= '0; dd_q <= '0; cd_q <= '0; idx_q <= '0;
      stop_q <= 1'b0; err_q <= ERR_NONE;
      for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == RegProgLen) plen_q <= pwdata[15:0];
      unique case (state_q)
        S_IDLE: if (in_if.valid) begin
          cmd_q <= in_if.cmd; a0_q <= in_if.arg_first; a1_q <= in_if.arg_second;
          a2_q <= in_if.arg_third; state_q <= S_READ;
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          logic [3:0]  e;
          logic [15:0] nx;
          logic        h, ov, go;
          logic [31:0] ovv;
          e = ERR_NONE; nx = 16'(idx_q + 16'd1); h = 1'b0; ov = 1'b0; ovv = '0;
          go = 1'b0;
          if (stop_q || idx_q >= plen_q) begin
            if (!stop_q) err_q <= ERR_NONE;
            stop_q <= 1'b1;
            onext_q <= idx_q; oval_q <= 1'b0; oval_v_q <= '0; ohalt_q <= 1'b1;
            oerr_q <= stop_q ? err_q : ERR_NONE;
            state_q <= S_OUT;
          end else begin
            case (cmd_q)
              OP_NOP: ;
              OP_PUSH: if (dd_q >= STACK_DEPTH[SW:0]) e = ERR_SOVER;
                       else dd_q <= dd_q + 1'b1;
              OP_POP: if (dd_q == 0) e = ERR_SUNDER; else dd_q <= dd_q - 1'b1;
              OP_ADD, OP_SUB, OP_MUL: if (dd_q < 2) e = ERR_SUNDER;
                                      else dd_q <= dd_q - 1'b1;
              OP_DIV: if (dd_q < 2) e = ERR_SUNDER;
                      else if (y_q == 0) e = ERR_DIV0;
                      else go = 1'b1;
              OP_SQRT: if (dd_q == 0) e = ERR_SUNDER;
                       else if (x_q[31]) e = ERR_NEGROOT;
                       else go = 1'b1;
              OP_JMP: nx = clampt(a0_q);
              OP_JGE, OP_JG, OP_JLE, OP_JL, OP_JE, OP_JNE:
                if (!ok1) e = ERR_BADREG;
                else if (take) nx = clampt(a0_q);
              OP_IN: if (!ok0) e = ERR_BADREG; else rf_q[a0_q[RW-1:0]] <= a1_q;
              OP_INREG: if (!ok0 || !ok1) e = ERR_BADREG;
                        else rf_q[a0_q[RW-1:0]] <= r1;
              OP_OUT: if (!ok0) e = ERR_BADREG; else begin ov = 1'b1; ovv = r0; end
              OP_ADDREG, OP_SUBREG, OP_MULREG:
                if (!ok0 || !ok1 || !ok2) e = ERR_BADREG;
                else rf_q[a2_q[RW-1:0]] <= (cmd_q == OP_ADDREG) ? r0 + r1 :
                                           (cmd_q == OP_SUBREG) ? r0 - r1 : mul_r;
              OP_DIVREG: if (!ok0 || !ok1 || !ok2) e = ERR_BADREG;
                         else if (r1 == 0) e = ERR_DIV0;
                         else go = 1'b1;
              OP_SQRTREG: if (!ok0 || !ok1) e = ERR_BADREG;
                          else if (r0[31]) e = ERR_NEGROOT;
                          else go = 1'b1;
              OP_CALL: if (cd_q >= CALL_DEPTH[CW:0]) e = ERR_COVER;
                       else begin cd_q <= cd_q + 1'b1; nx = clampt(a0_q); end
              OP_RET: if (cd_q == 0) e = ERR_CUNDER;
                      else begin cd_q <= cd_q - 1'b1; nx = ret_q; end
              OP_HLT: begin nx = plen_q; h = 1'b1; end
              default: e = ERR_BADOP;
            endcase
            if (e != ERR_NONE) begin
              stop_q <= 1'b1; err_q <= e;
              onext_q <= idx_q; oval_q <= 1'b0; oval_v_q <= '0; ohalt_q <= 1'b1;
              oerr_q <= e;
              state_q <= S_OUT;
            end else begin
              idx_q <= nx;
              onext_q <= nx; oval_q <= ov; oval_v_q <= ovv;
              if (h || nx >= plen_q) begin
                stop_q <= 1'b1; err_q <= ERR_NONE; ohalt_q <= 1'b1;
              end else ohalt_q <= 1'b0;
              oerr_q <= ERR_NONE;
              state_q <= go ? S_WAIT : S_OUT;
            end
          end
        end
        S_WAIT: begin
          if (ursp.done) begin
            if (cmd_q == OP_DIV) dd_q <= dd_q - 1'b1;
            if (cmd_q == OP_DIVREG) rf_q[a2_q[RW-1:0]] <= ursp.res;
            if (cmd_q == OP_SQRTREG) rf_q[a1_q[RW-1:0]] <= ursp.res;
            state_q <= S_OUT;
          end
        end
        S_OUT: if (out_if.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // the unit starts the cycle after execute decides to use it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= 1'b0;
    else start_q <= (state_q == S_EXEC) && (cmd_q == OP_DIV || cmd_q == OP_SQRT ||
                     cmd_q == OP_DIVREG || cmd_q == OP_SQRTREG);
  end
endmodule

// File: design/srce_checker.sv
// Port-level checker for the execute block, bound to the top level.
module srce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        halted,
  input logic        out_flag,
  input logic [3:0]  error_code
);
  // no new item while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // a pending result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // an error always stops the machine
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && error_code != 4'd0 |-> halted) else $error("error without halt");
  // no reported value with an error
  a_outerr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_flag |-> error_code == 4'd0) else $error("out with error");
endmodule

bind stack_register_cpu_execute srce_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .halted(out_if.halted),
  .out_flag(out_if.out_valid), .error_code(out_if.error_code)
);

// File: tb/sv/stack_register_cpu_execute_tb.sv
// Self-checking testbench for the stack/register CPU execute block.
module stack_register_cpu_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srce_pkg::*;

  localparam int unsigned NREGS     = NumRegsDef;
  localparam int unsigned SDEPTH    = StackDepthDef;
  localparam int unsigned CDEPTH    = CallDepthDef;
  localparam int unsigned MAX_CYC   = 1000000;
  localparam int unsigned HOLD_AT   = 2500;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned QUIET_LO  = 6000;
  localparam int unsigned QUIET_HI  = 12000;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_index;
    logic        out_valid;
    logic [31:0] out_value;
    logic        halted;
    logic [3:0]  error_code;
  } outcome_t;

  typedef struct {
    logic [31:0] rf [NREGS];
    logic [31:0] ds [SDEPTH];
    int unsigned dd;
    logic [15:0] rs [CDEPTH];
    int unsigned rd;
    logic [15:0] idx;
    bit          stopped;
    logic [3:0]  err;
  } cpu_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  srce_in_if  in_ch ();
  srce_out_if out_ch ();

  stack_register_cpu_execute dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cpu_t        cpu;
  logic [15:0] prog_len;
  instr_t      pending_q [$];
  outcome_t    expected_q [$];
  int unsigned fails = 0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;

  function automatic bit reg_ok(logic [31:0] v);
    return v < NREGS;
  endfunction

  function automatic logic [31:0] isqrt(logic [31:0] v);
    logic [31:0] x, res, b;
    x = v;
    res = 0;
    b = 32'h4000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Truncating divide; most negative over minus one wraps
  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [15:0] clamp_tgt(logic [31:0] v);
    if ($signed(v) < 0) return 16'd0;
    if ($signed(v) > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // One instruction against machine state s, giving new state and result item
  function automatic void exec_instr(input cpu_t s, input logic [15:0] plen,
                                     input instr_t it, output cpu_t n,
                                     output outcome_t r);
    logic [3:0]  e;
    logic [31:0] x, y, outv;
    logic [15:0] nxt;
    bit outok, halt, take;
    logic signed [31:0] rv, cv;
    n = s;
    e = ERR_NONE;
    outok = 0;
    halt = 0;
    outv = 0;
    nxt = s.idx + 16'd1;
    if (!n.stopped && n.idx >= plen) begin
      n.stopped = 1;
      n.err = ERR_NONE;
    end
    if (n.stopped) begin
      r = '{n.idx, 1'b0, 32'd0, 1'b1, n.err};
      return;
    end
    case (it.cmd)
      OP_NOP: ;
      OP_PUSH: begin
        if (n.dd >= SDEPTH) e = ERR_SOVER;
        else begin
          n.ds[n.dd] = it.a0;
          n.dd++;
        end
      end
      OP_POP: begin
        if (n.dd == 0) e = ERR_SUNDER;
        else n.dd--;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (n.dd < 2) e = ERR_SUNDER;
        else begin
          x = n.ds[n.dd-1];
          y = n.ds[n.dd-2];
          if (it.cmd == OP_DIV && y == 0) e = ERR_DIV0;
          else begin
            n.dd--;
            case (it.cmd)
              OP_ADD:  n.ds[n.dd-1] = x + y;
              OP_SUB:  n.ds[n.dd-1] = x - y;
              OP_MUL:  n.ds[n.dd-1] = x * y;
              default: n.ds[n.dd-1] = sdiv(x, y);
            endcase
          end
        end
      end
      OP_SQRT: begin
        if (n.dd == 0) e = ERR_SUNDER;
        else if (n.ds[n.dd-1][31]) e = ERR_NEGROOT;
        else n.ds[n.dd-1] = isqrt(n.ds[n.dd-1]);
      end
      OP_JMP: nxt = clamp_tgt(it.a0);
      OP_JGE, OP_JG, OP_JLE, OP_JL, OP_JE, OP_JNE: begin
        if (!reg_ok(it.a1)) e = ERR_BADREG;
        else begin
          rv = n.rf[it.a1];
          cv = it.a2;
          case (it.cmd)
            OP_JGE:  take = rv >= cv;
            OP_JG:   take = rv > cv;
            OP_JLE:  take = rv <= cv;
            OP_JL:   take = rv < cv;
            OP_JE:   take = rv == cv;
            default: take = rv != cv;
          endcase
          if (take) nxt = clamp_tgt(it.a0);
        end
      end
      OP_IN: begin
        if (!reg_ok(it.a0)) e = ERR_BADREG;
        else n.rf[it.a0] = it.a1;
      end
      OP_INREG: begin
        if (!reg_ok(it.a0) || !reg_ok(it.a1)) e = ERR_BADREG;
        else n.rf[it.a0] = n.rf[it.a1];
      end
      OP_OUT: begin
        if (!reg_ok(it.a0)) e = ERR_BADREG;
        else begin
          outok = 1;
          outv = n.rf[it.a0];
        end
      end
      OP_ADDREG, OP_SUBREG, OP_MULREG, OP_DIVREG: begin
        if (!reg_ok(it.a0) || !reg_ok(it.a1) || !reg_ok(it.a2)) e = ERR_BADREG;
        else begin
          x = n.rf[it.a0];
          y = n.rf[it.a1];
          if (it.cmd == OP_DIVREG && y == 0) e = ERR_DIV0;
          else begin
            case (it.cmd)
              OP_ADDREG: n.rf[it.a2] = x + y;
              OP_SUBREG: n.rf[it.a2] = x - y;
              OP_MULREG: n.rf[it.a2] = x * y;
              default:   n.rf[it.a2] = sdiv(x, y);
            endcase
          end
        end
      end
      OP_SQRTREG: begin
        if (!reg_ok(it.a0) || !reg_ok(it.a1)) e = ERR_BADREG;
        else if (n.rf[it.a0][31]) e = ERR_NEGROOT;
        else n.rf[it.a1] = isqrt(n.rf[it.a0]);
      end
      OP_CALL: begin
        if (n.rd >= CDEPTH) e = ERR_COVER;
        else begin
          n.rs[n.rd] = nxt;
          n.rd++;
          nxt = clamp_tgt(it.a0);
        end
      end
      OP_RET: begin
        if (n.rd == 0) e = ERR_CUNDER;
        else begin
          n.rd--;
          nxt = n.rs[n.rd];
        end
      end
      OP_HLT: begin
        nxt = plen;
        halt = 1;
      end
      default: e = ERR_BADOP;
    endcase
    if (e != ERR_NONE) begin
      // faulting instruction leaves everything but the stop flag and error code alone
      n = s;
      n.stopped = 1;
      n.err = e;
      outok = 0;
      outv = 0;
    end else begin
      n.idx = nxt;
      if (halt || n.idx >= plen) begin
        n.stopped = 1;
        n.err = ERR_NONE;
      end
    end
    r = '{n.idx, outok, outv, n.stopped, n.err};
  endfunction

  // Queue an item and the result it must cause
  task automatic send(instr_t it);
    cpu_t n;
    outcome_t r;
    exec_instr(cpu, prog_len, it, n, r);
    cpu = n;
    pending_q.push_back(it);
    expected_q.push_back(r);
  endtask

  function automatic logic [31:0] pick_reg();
    if ($urandom_range(99) < 92) return $urandom_range(NREGS-1);
    return $urandom;
  endfunction

  // Random instruction; in safe mode candidates that would stop the machine are retried
  task automatic send_random(bit safe, bit any_op);
    instr_t it;
    cpu_t n;
    outcome_t r;
    int tries;
    for (tries = 0; tries < 20; tries++) begin
      it.cmd = any_op ? 5'($urandom_range(31)) : 5'($urandom_range(OP_HLT));
      it.a0 = $urandom;
      it.a1 = $urandom;
      it.a2 = $urandom;
      case (it.cmd)
        OP_JMP, OP_CALL, OP_JGE, OP_JG, OP_JLE, OP_JL, OP_JE, OP_JNE: begin
          if ($urandom_range(99) < 80 && prog_len > 1)
            it.a0 = $urandom_range(prog_len - 1);
          if (it.cmd >= OP_JGE) begin
            it.a1 = pick_reg();
            if ($urandom_range(1) && reg_ok(it.a1)) it.a2 = cpu.rf[it.a1];
          end
        end
        OP_IN: it.a0 = pick_reg();
        OP_INREG, OP_OUT, OP_SQRTREG: begin
          it.a0 = pick_reg();
          it.a1 = pick_reg();
        end
        OP_ADDREG, OP_SUBREG, OP_MULREG, OP_DIVREG: begin
          it.a0 = pick_reg();
          it.a1 = pick_reg();
          it.a2 = pick_reg();
        end
        default: ;
      endcase
      exec_instr(cpu, prog_len, it, n, r);
      if (!safe || !r.halted) break;
    end
    if (safe && r.halted) it = '{OP_NOP, 32'd0, 32'd0, 32'd0};
    send(it);
  endtask

  task automatic apb_write(logic [AddrW-1:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == RegProgLen) prog_len = d[15:0];
  endtask

  task automatic wait_idle();
    wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic bit quiet();
    return cyc >= QUIET_LO && cyc < QUIET_HI;
  endfunction

  // Stimulus, configuration phases and end of run
  initial begin
    int i;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.arg_first = '0;
    in_ch.arg_second = '0;
    in_ch.arg_third = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (cpu.rf[k]) cpu.rf[k] = '0;
    cpu.dd = 0;
    cpu.rd = 0;
    cpu.idx = 0;
    cpu.stopped = 0;
    cpu.err = ERR_NONE;
    prog_len = 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_write(RegProgLen, 32'hFFFF_FFFF);
    // directed: field extremes, wraps, min over minus one, clamped jumps
    send('{OP_PUSH, 32'h7FFF_FFFF, 32'd0, 32'd0});
    send('{OP_PUSH, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send('{OP_ADD, 32'd0, 32'd0, 32'd0});
    send('{OP_PUSH, 32'hFFFF_FFFF, 32'd0, 32'd0});
    send('{OP_PUSH, 32'h8000_0000, 32'd0, 32'd0});
    send('{OP_DIV, 32'd0, 32'd0, 32'd0});
    send('{OP_SUB, 32'd0, 32'd0, 32'd0});
    send('{OP_PUSH, 32'h7FFF_FFFF, 32'd0, 32'd0});
    send('{OP_SQRT, 32'd0, 32'd0, 32'd0});
    send('{OP_MUL, 32'd0, 32'd0, 32'd0});
    send('{OP_POP, 32'd0, 32'd0, 32'd0});
    send('{OP_IN, 32'd0, 32'h8000_0000, 32'd0});
    send('{OP_IN, 32'd7, 32'h7FFF_FFFF, 32'd0});
    send('{OP_ADDREG, 32'd0, 32'd7, 32'd3});
    send('{OP_SUBREG, 32'd0, 32'd7, 32'd4});
    send('{OP_MULREG, 32'd7, 32'd7, 32'd5});
    send('{OP_DIVREG, 32'd0, 32'd7, 32'd6});
    send('{OP_SQRTREG, 32'd7, 32'd1, 32'd0});
    send('{OP_INREG, 32'd2, 32'd0, 32'd0});
    send('{OP_OUT, 32'd7, 32'd0, 32'd0});
    send('{OP_JL, 32'hFFFF_FFFF, 32'd0, 32'd0});
    send('{OP_JE, 32'd9, 32'd0, 32'h7FFF_FFFF});
    send('{OP_JMP, 32'd100, 32'd0, 32'd0});
    send('{OP_CALL, 32'd200, 32'd0, 32'd0});
    send('{OP_RET, 32'd0, 32'd0, 32'd0});
    send('{OP_JNE, 32'd1000, 32'd3, 32'h8000_0000});
    for (i = 0; i < 650; i++) send_random(1'b1, 1'b0);

    // shorter program around the current index
    wait_idle();
    apb_write(RegProgLen, (cpu.idx > 65535 - 400) ? 32'hFFFF : cpu.idx + 400);
    for (i = 0; i < 600; i++) send_random(1'b1, 1'b0);

    // free run: faults, halt, end of program and bad opcodes may stop it
    wait_idle();
    apb_write(RegProgLen, (cpu.idx > 65535 - 60) ? 32'hFFFF : cpu.idx + 60);
    for (i = 0; i < 80; i++) send_random(1'b0, 1'b1);

    // zero length: a started-past-the-end step, then items while stopped
    wait_idle();
    apb_write(RegProgLen, 32'd0);
    for (i = 0; i < 10; i++) send_random(1'b0, 1'b1);

    wait (pending_q.size() == 0 && !in_ch.valid);
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Driver: offers queued items, idling at random
  always @(posedge clk) begin
    if (rst_n && (!in_ch.valid || in_ch.ready)) begin
      if (pending_q.size() > 0 && (quiet() || $urandom_range(99) >= 6)) begin
        instr_t it;
        it = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= it.cmd;
        in_ch.arg_first <= it.a0;
        in_ch.arg_second <= it.a1;
        in_ch.arg_third <= it.a2;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks accepted results against the oldest expectation
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
    if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual next_index %0d",
                 $realtime, out_ch.next_index);
        fails++;
      end else begin
        outcome_t ex;
        ex = expected_q.pop_front();
        if (out_ch.next_index !== ex.next_index) begin
          $display("%0t: next_index expected %0d actual %0d", $realtime,
                   ex.next_index, out_ch.next_index);
          fails++;
        end
        if (out_ch.out_valid !== ex.out_valid) begin
          $display("%0t: out_valid expected %0b actual %0b", $realtime,
                   ex.out_valid, out_ch.out_valid);
          fails++;
        end
        if (out_ch.out_value !== ex.out_value) begin
          $display("%0t: out_value expected %h actual %h", $realtime,
                   ex.out_value, out_ch.out_value);
          fails++;
        end
        if (out_ch.halted !== ex.halted) begin
          $display("%0t: halted expected %0b actual %0b", $realtime,
                   ex.halted, out_ch.halted);
          fails++;
        end
        if (out_ch.error_code !== ex.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $realtime,
                   ex.error_code, out_ch.error_code);
          fails++;
        end
      end
    end
    // long hold-off once, otherwise random stalls outside the quiet window
    if (cyc == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && (quiet() || $urandom_range(99) >= 6);
    end
  end
endmodule
